@@ sv/hsv_to_rgb_pixel_convert_core_defines.svh @@
// Assertion macros shared by the HSV to RGB converter RTL.
`ifndef HSV_TO_RGB_PIXEL_CONVERT_CORE_DEFINES_SVH
`define HSV_TO_RGB_PIXEL_CONVERT_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HSVRGB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hsvrgb assertion failed");

// Fixed-delay implication in clock cycles, disabled while reset is asserted.
`define HSVRGB_ASSERT_DELAY(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##dly (cons)) \
    else $error("hsvrgb assertion failed");

`endif

@@ sv/hsvrgb_pkg.sv @@
// Shared constants, types and functions for the HSV to RGB converter.
package hsvrgb_pkg;

  localparam int HUE_FRAC_BITS  = 4;
  localparam int UNIT_FRAC_BITS = 12;

  localparam int HUE_FULL = 360 << HUE_FRAC_BITS;  // 5760
  localparam int SECT_W   = 60 << HUE_FRAC_BITS;   // 960
  localparam int HUE_OFS  = 6 * HUE_FULL;          // lifts any 16-bit hue above zero
  localparam int UNIT     = 1 << UNIT_FRAC_BITS;

  localparam int UW     = 17;                      // lifted hue
  localparam int HW     = 13;                      // hue after wrap, below HUE_FULL
  localparam int SW     = 3;                       // sector index
  localparam int XWW    = 10;                      // ramp weight, 0..SECT_W
  localparam int VW     = UNIT_FRAC_BITS + 1;      // clamped unit value
  localparam int PW     = 2 * UNIT_FRAC_BITS + 1;  // v*s
  localparam int NW     = 34;                      // channel numerator over D
  localparam int QW     = 44;                      // 510*n + D
  localparam int TW     = 13;                      // numerator after the 2^31 shift
  localparam int QSHIFT = 31;                      // 2*D = 15 * 2^31

  // Reciprocals for exact floor division of small values.
  localparam int RECIP45 = 1457;  // x/45 for x < 2259, as (x*RECIP45) >> 16
  localparam int RECIP15 = 4370;  // x/15 for x < 4681, as (x*RECIP15) >> 16

  localparam logic [2:0] SECTOR_R_Y = 3'd0;
  localparam logic [2:0] SECTOR_Y_G = 3'd1;
  localparam logic [2:0] SECTOR_G_C = 3'd2;
  localparam logic [2:0] SECTOR_C_B = 3'd3;
  localparam logic [2:0] SECTOR_B_M = 3'd4;
  localparam logic [2:0] SECTOR_M_R = 3'd5;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_e;

  typedef enum logic [1:0] {
    ROLE_FULL = 2'd0,
    ROLE_RAMP = 2'd1,
    ROLE_ZERO = 2'd2
  } role_e;

  typedef struct packed {
    logic [SW-1:0]  sector;
    logic [XWW-1:0] xw;
    logic [PW-1:0]  p;
    logic [VW-1:0]  v;
  } front_t;

  // Clamp a signed Q3.12 value into 0..UNIT.
  function automatic logic [VW-1:0] clamp_unit(input logic signed [15:0] val);
    logic [VW-1:0] res;
    if (val[15]) begin
      res = '0;
    end else if (val > 16'(UNIT)) begin
      res = VW'(UNIT);
    end else begin
      res = val[VW-1:0];
    end
    return res;
  endfunction

  // Which component a channel carries in a given sector.
  function automatic role_e chan_role(input chan_e ch, input logic [SW-1:0] sec);
    role_e r;
    r = ROLE_ZERO;
    case (ch)
      CH_RED: begin
        case (sec)
          SECTOR_R_Y, SECTOR_M_R: r = ROLE_FULL;
          SECTOR_Y_G, SECTOR_B_M: r = ROLE_RAMP;
          default:                r = ROLE_ZERO;
        endcase
      end
      CH_GREEN: begin
        case (sec)
          SECTOR_Y_G, SECTOR_G_C: r = ROLE_FULL;
          SECTOR_R_Y, SECTOR_C_B: r = ROLE_RAMP;
          default:                r = ROLE_ZERO;
        endcase
      end
      CH_BLUE: begin
        case (sec)
          SECTOR_C_B, SECTOR_B_M: r = ROLE_FULL;
          SECTOR_G_C, SECTOR_M_R: r = ROLE_RAMP;
          default:                r = ROLE_ZERO;
        endcase
      end
      default: r = ROLE_ZERO;
    endcase
    return r;
  endfunction

endpackage

@@ sv/hsv_to_rgb_pixel_convert_core.sv @@
// Top level of the HSV to RGB pixel converter.
//
//  Channel   Ports                                          Handshake
//  -------   ---------------------------------------------  ---------------------------
//  input     hue_i, saturation_i, brightness_i              start high, busy low
//  result    packed_color_o, red_o, green_o, blue_o         valid_o, one cycle, no stall
//
// One item is accepted in every cycle; busy is always low.
// The pipeline has three front stages (hue wrap, sector, ramp weight and
// chroma product) and three channel stages (product, rounding, divide by 15).
// Reset clears only the valid bits of the pipeline.
// Results cannot be held off, so the pipeline never stalls.
`include "hsv_to_rgb_pixel_convert_core_defines.svh"

module hsv_to_rgb_pixel_convert_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] hue_i,
  input  logic signed [15:0] saturation_i,
  input  logic signed [15:0] brightness_i,
  output logic               valid_o,
  output logic [31:0]        packed_color_o,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         blue_o
);

  logic               accept;
  logic               front_valid;
  hsvrgb_pkg::front_t front;
  logic [2:0]         valid_q;
  logic [7:0]         red, green, blue;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  hsvrgb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (accept),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .valid_o      (front_valid),
    .front_o      (front)
  );

  hsvrgb_chan u_red (
    .clk_i   (clk_i),
    .chan_i  (hsvrgb_pkg::CH_RED),
    .front_i (front),
    .level_o (red)
  );

  hsvrgb_chan u_green (
    .clk_i   (clk_i),
    .chan_i  (hsvrgb_pkg::CH_GREEN),
    .front_i (front),
    .level_o (green)
  );

  hsvrgb_chan u_blue (
    .clk_i   (clk_i),
    .chan_i  (hsvrgb_pkg::CH_BLUE),
    .front_i (front),
    .level_o (blue)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[1:0], front_valid};
    end
  end

  assign valid_o        = valid_q[2];
  assign red_o          = red;
  assign green_o        = green;
  assign blue_o         = blue;
  assign packed_color_o = {8'hFF, red, green, blue};

  // Every accepted item comes out, and no result appears without an accepted item.
  `HSVRGB_ASSERT_DELAY(a_latency, accept, 6, valid_o)
  `HSVRGB_ASSERT_NOW(a_no_phantom, valid_o, $past(accept, 6))
  // A negative brightness clamps to black.
  `HSVRGB_ASSERT_NOW(a_black, valid_o && $past(accept && brightness_i[15], 6),
                     red_o == 8'd0 && green_o == 8'd0 && blue_o == 8'd0)
  // A negative saturation clamps to gray, so all channels agree.
  `HSVRGB_ASSERT_NOW(a_gray, valid_o && $past(accept && saturation_i[15], 6),
                     red_o == green_o && green_o == blue_o)

endmodule

@@ sv/hsvrgb_front.sv @@
// Front pipeline: clamps, hue wrap, sector split and chroma product (three stages).
module hsvrgb_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [15:0]   hue_i,
  input  logic signed [15:0]   saturation_i,
  input  logic signed [15:0]   brightness_i,
  output logic                 valid_o,
  output hsvrgb_pkg::front_t   front_o
);

  // Stage 1: clamp, lift hue positive, estimate wrap count.
  logic [2:0]                   valid_q;
  logic [hsvrgb_pkg::UW-1:0]    u_d, u_q;
  logic [20:0]                  wrap_prod;
  logic [3:0]                   wrap_d, wrap_q;
  logic [hsvrgb_pkg::VW-1:0]    s1_s_q, s1_v_q;

  // Stage 2: wrapped hue, sector, v*s.
  logic [hsvrgb_pkg::UW-1:0]    h_full;
  logic [hsvrgb_pkg::HW-1:0]    h_d, h_q;
  logic [19:0]                  sect_prod;
  logic [hsvrgb_pkg::SW-1:0]    sect_d, sect_q;
  logic [2*hsvrgb_pkg::VW-1:0]  p_full;
  logic [hsvrgb_pkg::PW-1:0]    p_q;
  logic [hsvrgb_pkg::VW-1:0]    s2_v_q;

  // Stage 3: offset in sector and ramp weight.
  logic [hsvrgb_pkg::HW-1:0]    f_full;
  logic [hsvrgb_pkg::XWW-1:0]   f_off;
  logic [hsvrgb_pkg::XWW-1:0]   xw_d;
  hsvrgb_pkg::front_t           front_q;

  assign u_d       = hsvrgb_pkg::UW'({hue_i[15], hue_i}) + hsvrgb_pkg::UW'(hsvrgb_pkg::HUE_OFS);
  assign wrap_prod = 21'(u_d[hsvrgb_pkg::UW-1:7]) * 21'(hsvrgb_pkg::RECIP45);
  assign wrap_d    = wrap_prod[19:16];

  assign h_full    = u_q - hsvrgb_pkg::UW'(wrap_q) * hsvrgb_pkg::UW'(hsvrgb_pkg::HUE_FULL);
  assign h_d       = h_full[hsvrgb_pkg::HW-1:0];
  assign sect_prod = 20'(h_d[hsvrgb_pkg::HW-1:6]) * 20'(hsvrgb_pkg::RECIP15);
  assign sect_d    = sect_prod[18:16];
  assign p_full    = s1_v_q * s1_s_q;

  assign f_full = h_q - hsvrgb_pkg::HW'(sect_q) * hsvrgb_pkg::HW'(hsvrgb_pkg::SECT_W);
  assign f_off  = f_full[hsvrgb_pkg::XWW-1:0];
  // The ramp weight is SECT_W minus the offset in even sectors and the offset itself in odd sectors.
  assign xw_d   = sect_q[0] ? f_off : hsvrgb_pkg::XWW'(hsvrgb_pkg::SECT_W) - f_off;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    u_q            <= u_d;
    wrap_q         <= wrap_d;
    s1_s_q         <= hsvrgb_pkg::clamp_unit(saturation_i);
    s1_v_q         <= hsvrgb_pkg::clamp_unit(brightness_i);
    h_q            <= h_d;
    sect_q         <= sect_d;
    p_q            <= p_full[hsvrgb_pkg::PW-1:0];
    s2_v_q         <= s1_v_q;
    front_q.sector <= sect_q;
    front_q.xw     <= xw_d;
    front_q.p      <= p_q;
    front_q.v      <= s2_v_q;
  end

  assign valid_o = valid_q[2];
  assign front_o = front_q;

endmodule

@@ sv/hsvrgb_chan.sv @@
// Channel pipeline: numerator, rounding and division by fifteen (three stages).
module hsvrgb_chan (
  input  logic                clk_i,
  input  hsvrgb_pkg::chan_e   chan_i,
  input  hsvrgb_pkg::front_t  front_i,
  output logic [7:0]          level_o
);

  logic [hsvrgb_pkg::XWW-1:0] wsel;
  logic [hsvrgb_pkg::NW-1:0]  prod_d, prod_q;
  logic [hsvrgb_pkg::NW-1:0]  vuw_d, vuw_q;
  logic [hsvrgb_pkg::NW-1:0]  num;
  logic [hsvrgb_pkg::QW-1:0]  rnd;
  logic [hsvrgb_pkg::TW-1:0]  t_q;
  logic [25:0]                div_prod;
  logic [7:0]                 level_q;

  // The channel numerator is v*U*W - v*s*wsel, where wsel is zero for the
  // full component, SECT_W for none and the ramp weight for the secondary.
  always_comb begin
    case (hsvrgb_pkg::chan_role(chan_i, front_i.sector))
      hsvrgb_pkg::ROLE_FULL: wsel = '0;
      hsvrgb_pkg::ROLE_RAMP: wsel = front_i.xw;
      default:               wsel = hsvrgb_pkg::XWW'(hsvrgb_pkg::SECT_W);
    endcase
  end

  assign prod_d = hsvrgb_pkg::NW'(front_i.p) * hsvrgb_pkg::NW'(wsel);
  assign vuw_d  = (hsvrgb_pkg::NW'(front_i.v) * hsvrgb_pkg::NW'(hsvrgb_pkg::SECT_W))
                  << hsvrgb_pkg::UNIT_FRAC_BITS;

  // 510*n + D, then the power-of-two part of 2*D is shifted out.
  assign num = vuw_q - prod_q;
  assign rnd = (hsvrgb_pkg::QW'(num) << 9) - (hsvrgb_pkg::QW'(num) << 1)
             + (hsvrgb_pkg::QW'(hsvrgb_pkg::SECT_W) << (2 * hsvrgb_pkg::UNIT_FRAC_BITS));

  assign div_prod = 26'(t_q) * 26'(hsvrgb_pkg::RECIP15);

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    vuw_q   <= vuw_d;
    t_q     <= rnd[hsvrgb_pkg::QSHIFT +: hsvrgb_pkg::TW];
    level_q <= div_prod[23:16];
  end

  assign level_o = level_q;

endmodule
